// ----- sv/mhcs_pkg.sv -----
// Shared types and constants for the MPPT hill-climb search block.
// No dependencies; mhcs_step and mppt_hill_climb_search take names from here.
`default_nettype none

package mhcs_pkg;

	localparam int ADC_W  = 12;
	localparam int SP_W   = 16;
	localparam int PW_W   = 24;
	localparam int CELL_W = 4;
	// Number of cell indexes that the cell field can name
	localparam int CELL_IDS = 1 << CELL_W;

	typedef logic [ADC_W-1:0]  adc_t;
	typedef logic [SP_W-1:0]   setpoint_t;
	typedef logic [PW_W-1:0]   power_t;
	typedef logic [CELL_W-1:0] cell_t;

	// Setpoint clamp applied when a search finishes
	localparam setpoint_t SP_LIMIT = 16'h0FFF;
	localparam setpoint_t SP_CLAMP = 16'h0FFE;

	// Input action codes
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Result kind codes
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_DONE   = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BASE = 2'd1,
		PH_UP   = 2'd2,
		PH_DOWN = 2'd3
	} phase_t;

	typedef struct packed {
		logic  action;
		cell_t cell_req;
		adc_t  adc_voltage;
		adc_t  adc_current;
	} in_item_t;

	typedef struct packed {
		logic      kind;
		setpoint_t setpoint;
		power_t    best_power;
		cell_t     result_cell;
	} out_item_t;

	// Search registers
	typedef struct packed {
		phase_t    phase;
		cell_t     act_cell;
		setpoint_t work;
		power_t    prev;
	} search_t;

	// Item as seen by the decision logic, stored setpoint already resolved
	typedef struct packed {
		logic      action;
		cell_t     cell_id;
		logic      in_range;
		power_t    power;
		setpoint_t stored;
	} step_item_t;

	// Decision outputs
	typedef struct packed {
		logic      emit;
		out_item_t item;
		logic      wr_en;
		setpoint_t wr_data;
	} step_out_t;

endpackage

`default_nettype wire

// ----- sv/mhcs_stream_if.sv -----
// Valid/ready stream channel carrying one item of type T.
// Depends on nothing; payload types come from mhcs_pkg at the instance.
`default_nettype none

interface mhcs_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/mhcs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mhcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read returns old data on a same-address write; caller forwards
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/mhcs_step.sv -----
// Hill-climb decision logic: next search registers and result for one item.
// Depends on mhcs_pkg.
`default_nettype none

module mhcs_step (
	input  mhcs_pkg::search_t    cur,
	input  mhcs_pkg::step_item_t item,
	output mhcs_pkg::search_t    nxt,
	output mhcs_pkg::step_out_t  res
);

	mhcs_pkg::setpoint_t sp_p1, sp_p2, sp_m1, sp_m2, sp_final;
	logic                rising;

	assign sp_p1    = cur.work + mhcs_pkg::setpoint_t'(1);
	assign sp_p2    = cur.work + mhcs_pkg::setpoint_t'(2);
	assign sp_m1    = cur.work - mhcs_pkg::setpoint_t'(1);
	assign sp_m2    = cur.work - mhcs_pkg::setpoint_t'(2);
	assign sp_final = (cur.work >= mhcs_pkg::SP_LIMIT) ? mhcs_pkg::SP_CLAMP : cur.work;
	assign rising   = item.power > cur.prev;

	// Next search registers
	always_comb begin
		nxt = cur;
		if (item.action == mhcs_pkg::ACT_START) begin
			if (item.in_range) begin
				nxt.phase    = mhcs_pkg::PH_BASE;
				nxt.act_cell = item.cell_id;
				nxt.work     = item.stored;
				nxt.prev     = '0;
			end
		end else begin
			case (cur.phase)
				mhcs_pkg::PH_BASE: begin
					nxt.prev  = item.power;
					nxt.phase = mhcs_pkg::PH_UP;
				end
				mhcs_pkg::PH_UP: begin
					if (rising) begin
						nxt.work = sp_p1;
						nxt.prev = item.power;
					end else begin
						nxt.phase = mhcs_pkg::PH_DOWN;
					end
				end
				mhcs_pkg::PH_DOWN: begin
					if (rising) begin
						nxt.work = sp_m1;
						nxt.prev = item.power;
					end else begin
						nxt.work  = sp_final;
						nxt.phase = mhcs_pkg::PH_IDLE;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

	// Result item and setpoint store write
	always_comb begin
		res.emit             = 1'b0;
		res.item.kind        = mhcs_pkg::KIND_SAMPLE;
		res.item.setpoint    = '0;
		res.item.best_power  = '0;
		res.item.result_cell = nxt.act_cell;
		res.wr_en            = 1'b0;
		res.wr_data          = sp_final;
		if (item.action == mhcs_pkg::ACT_START) begin
			res.emit          = item.in_range;
			res.item.setpoint = item.stored;
		end else begin
			case (cur.phase)
				mhcs_pkg::PH_BASE: begin
					res.emit          = 1'b1;
					res.item.setpoint = sp_p1;
				end
				mhcs_pkg::PH_UP: begin
					res.emit          = 1'b1;
					res.item.setpoint = rising ? sp_p2 : sp_m1;
				end
				mhcs_pkg::PH_DOWN: begin
					res.emit = 1'b1;
					if (rising) begin
						res.item.setpoint = sp_m2;
					end else begin
						res.item.kind       = mhcs_pkg::KIND_DONE;
						res.item.setpoint   = sp_final;
						res.item.best_power = cur.prev;
						res.wr_en           = 1'b1;
					end
				end
				default: begin
					res.emit = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/mppt_hill_climb_search.sv -----
// Per-cell maximum power point search by hill climbing (perturb and observe).
// Depends on mhcs_pkg, mhcs_stream_if, mhcs_ram and mhcs_step.
//
// Usage: cmd carries start items (pick a cell) and sample replies (ADC
// voltage and current for the last requested setpoint). res carries DAC
// requests (kind sample) and the end of a search (kind done, with the final
// stored setpoint and best power). A start for a cell at or above CELL_COUNT,
// or a sample with no search running, gives no result.
//
// Throughput: one item per cycle while res is not stalled. The stored
// setpoints sit in a RAM with a registered read, issued when the item is
// accepted; the item then waits one stage for that data plus its registered
// power product, then passes into the result register that drives res.valid.
// A store at the end of a search forwards into a start accepted in the same
// cycle.
//
// Reset: all setpoints read as zero through per-cell valid bits; no clearing
// pass is needed, cmd is ready right after reset. When res stalls, the item
// in the stage holds and cmd.ready drops until the result register frees.
`default_nettype none

module mppt_hill_climb_search #(
	parameter int CELL_COUNT = 16,
	parameter int ADC_BITS   = 12
) (
	input logic          clk,
	input logic          arst_n,
	mhcs_stream_if.sink   cmd,
	mhcs_stream_if.source res
);

	localparam int DEPTH = (CELL_COUNT > mhcs_pkg::CELL_IDS) ? mhcs_pkg::CELL_IDS : CELL_COUNT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EFF_W = (ADC_BITS < mhcs_pkg::ADC_W) ? ADC_BITS : mhcs_pkg::ADC_W;
	localparam mhcs_pkg::adc_t ADC_MASK = {mhcs_pkg::ADC_W{1'b1}} >> (mhcs_pkg::ADC_W - EFF_W);

	// Stage and output registers
	logic                s1_valid_q;
	logic                act_s1;
	mhcs_pkg::cell_t     cell_s1;
	logic                in_range_s1;
	mhcs_pkg::power_t    pw_s1;
	logic                vld_s1;
	logic                fwd_s1;
	mhcs_pkg::setpoint_t fwd_data_s1;
	logic                out_valid_q;
	mhcs_pkg::out_item_t out_q;
	mhcs_pkg::search_t   search_q;
	logic [DEPTH-1:0]    cell_valid_q;

	logic                 accept, s1_adv, in_range;
	logic [AW-1:0]        raddr, waddr;
	logic                 ram_we;
	mhcs_pkg::setpoint_t  ram_rdata;
	mhcs_pkg::adc_t       v_m, c_m;
	mhcs_pkg::step_item_t step_item;
	mhcs_pkg::search_t    search_nxt;
	mhcs_pkg::step_out_t  step_res;

	// Handshake
	assign s1_adv    = s1_valid_q && (!out_valid_q || res.ready);
	assign cmd.ready = !s1_valid_q || s1_adv;
	assign accept    = cmd.valid && cmd.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	assign in_range = int'(cmd.data.cell_req) < CELL_COUNT;
	assign raddr    = cmd.data.cell_req[AW-1:0];
	assign waddr    = search_q.act_cell[AW-1:0];
	assign ram_we   = s1_adv && step_res.wr_en;
	assign v_m      = cmd.data.adc_voltage & ADC_MASK;
	assign c_m      = cmd.data.adc_current & ADC_MASK;

	mhcs_ram #(
		.WIDTH(mhcs_pkg::SP_W),
		.DEPTH(DEPTH)
	) u_sp_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(step_res.wr_data),
		.re   (accept),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	// Stage 1 payload: fields, power product, forward of a same-cell store
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1      <= cmd.data.action;
			cell_s1     <= cmd.data.cell_req;
			in_range_s1 <= in_range;
			pw_s1       <= mhcs_pkg::power_t'(v_m) * mhcs_pkg::power_t'(c_m);
			vld_s1      <= cell_valid_q[raddr];
			fwd_s1      <= ram_we && (waddr == raddr);
			fwd_data_s1 <= step_res.wr_data;
		end
	end

	// Resolved item for the decision logic
	always_comb begin
		step_item.action   = act_s1;
		step_item.cell_id  = cell_s1;
		step_item.in_range = in_range_s1;
		step_item.power    = pw_s1;
		if (fwd_s1) begin
			step_item.stored = fwd_data_s1;
		end else if (vld_s1) begin
			step_item.stored = ram_rdata;
		end else begin
			step_item.stored = '0;
		end
	end

	mhcs_step u_step (
		.cur (search_q),
		.item(step_item),
		.nxt (search_nxt),
		.res (step_res)
	);

	// Search registers and per-cell valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_q     <= '{phase: mhcs_pkg::PH_IDLE, act_cell: '0, work: '0, prev: '0};
			cell_valid_q <= '0;
		end else if (s1_adv) begin
			search_q <= search_nxt;
			if (step_res.wr_en) begin
				cell_valid_q[waddr] <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= step_res.emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && step_res.emit) begin
			out_q <= step_res.item;
		end
	end

	// Assertions
	a_store_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> search_q.phase == mhcs_pkg::PH_IDLE)
		else $error("search still running after setpoint store");

	a_store_from_down: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> search_q.phase == mhcs_pkg::PH_DOWN)
		else $error("setpoint store outside the downward phase");

	a_store_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> step_res.wr_data < mhcs_pkg::SP_LIMIT)
		else $error("stored setpoint not clamped");

	a_cell_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		search_q.phase != mhcs_pkg::PH_IDLE |-> int'(search_q.act_cell) < CELL_COUNT)
		else $error("active cell out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> cmd.ready)
		else $error("cmd not ready with empty stage");

endmodule

`default_nettype wire
